@@ hw/rtl/lfa_pkg.sv @@
`default_nettype none

package lfa_pkg;

  localparam int ID_W   = 15;
  localparam int WORD_W = 64;
  localparam int OFF_W  = 6;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } lfa_state_e;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } lfa_op_e;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] idx;
  } lfa_hit_t;

endpackage

`default_nettype wire

@@ hw/rtl/lfa_map_ram.sv @@
`default_nettype none

module lfa_map_ram import lfa_pkg::*; #(
  parameter int Depth = 512,
  parameter int AddrW = 9
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AddrW-1:0]  wr_addr_i,
  input  wire logic [WORD_W-1:0] wr_data_i,
  input  wire logic [AddrW-1:0]  rd_addr_i,
  output logic      [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/lfa_word_search.sv @@
`default_nettype none

module lfa_word_search import lfa_pkg::*; #(
  parameter logic [WORD_W-1:0] LimitMask = '1
) (
  input  wire logic [WORD_W-1:0] word_i,
  input  wire logic [OFF_W-1:0]  lo_i,
  input  wire logic              last_i,
  output lfa_hit_t               hit_o
);

  logic [WORD_W-1:0] free;

  assign free = ~word_i & ({WORD_W{1'b1}} << lo_i) & (last_i ? LimitMask : {WORD_W{1'b1}});

  always_comb begin
    hit_o = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free[b]) begin
        hit_o.found = 1'b1;
        hit_o.idx   = OFF_W'(b);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lowest_free_id_allocator_core.sv @@
`default_nettype none

// Lowest-free identifier allocator over a used/free bitmap held in a
// one-port-read, one-port-write memory of 64-bit words. After reset the
// block runs a clearing pass over all ceil(ID_COUNT/64) words (512 by
// default) with in_stall_o high. An allocate request scans the map one
// word per cycle from the word of its start identifier, reading 1 to 512
// words by default, and passes through ST_READ, ST_EVAL for each word and
// ST_DONE before its result is loaded into the output register; the next
// request is taken in ST_IDLE after that. A release request passes through
// ST_READ, ST_EVAL and ST_DONE; one rejected on its identifier alone goes
// straight to ST_DONE. One request is in work at a time; a finished result
// waits in the output register while the next request is taken, and a
// held result that is still stalled delays the following one.
module lowest_free_id_allocator_core import lfa_pkg::*; #(
  parameter int ID_COUNT = 32768
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            op_i,
  input  wire logic [ID_W-1:0] start_id_i,
  input  wire logic [ID_W-1:0] release_id_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic      [ID_W-1:0] granted_id_o,
  output logic                 ok_o
);

  localparam int Words    = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int AddrW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int LastBits = ID_COUNT - (Words - 1) * WORD_W;
  localparam logic [WORD_W-1:0] LastMask =
    (LastBits >= WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << LastBits) - 64'd1);
  localparam logic [ID_W:0]    IdLimit  = (ID_W + 1)'(ID_COUNT);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Words - 1);

  lfa_state_e state_q, state_d;
  lfa_op_e    op_q, op_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [ID_W-1:0]  res_id_q, res_id_d;
  logic             res_ok_q, res_ok_d;
  logic             out_valid_q, out_valid_d;
  logic [ID_W-1:0]  out_id_q, out_id_d;
  logic             out_ok_q, out_ok_d;

  logic              accept;
  logic [ID_W-1:0]   start_eff;
  logic [ID_W-1:0]   id_sel;
  logic [ID_W-OFF_W-1:0] word_sel;
  logic              alloc_bad;
  logic              release_bad;
  logic              last_word;
  logic [AddrW-1:0]  next_addr;
  logic              out_load;

  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [AddrW-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;
  lfa_hit_t          hit;

  lfa_map_ram #(
    .Depth (Words),
    .AddrW (AddrW)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lfa_word_search #(
    .LimitMask (LastMask)
  ) u_search (
    .word_i (rd_data),
    .lo_i   (off_q),
    .last_i (last_word),
    .hit_o  (hit)
  );

  assign in_stall_o   = (state_q != ST_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign start_eff    = (start_id_i == '0) ? ID_W'(1) : start_id_i;
  assign alloc_bad    = ({1'b0, start_eff} >= IdLimit);
  assign release_bad  = (release_id_i == '0) || ({1'b0, release_id_i} >= IdLimit);
  assign id_sel       = (lfa_op_e'(op_i) == OP_ALLOC) ? start_eff : release_id_i;
  assign word_sel     = id_sel[ID_W-1:OFF_W];
  assign last_word    = (addr_q == LastAddr);
  assign next_addr    = last_word ? addr_q : addr_q + AddrW'(1);
  assign out_load     = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if ((lfa_op_e'(op_i) == OP_ALLOC) ? alloc_bad : release_bad) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        if (op_q == OP_RELEASE || hit.found || last_word) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    addr_d      = addr_q;
    off_d       = off_q;
    clr_d       = clr_q;
    res_id_d    = res_id_q;
    res_ok_d    = res_ok_q;
    out_id_d    = out_id_q;
    out_ok_d    = out_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_addr     = addr_q;
    wr_data     = rd_data;
    rd_addr     = addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AddrW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          op_d     = lfa_op_e'(op_i);
          addr_d   = word_sel[AddrW-1:0];
          off_d    = id_sel[OFF_W-1:0];
          res_id_d = '0;
          res_ok_d = 1'b0;
        end
      end
      ST_READ: begin
        rd_addr = addr_q;
      end
      ST_EVAL: begin
        rd_addr = next_addr;
        if (op_q == OP_RELEASE) begin
          if (rd_data[off_q]) begin
            wr_en    = 1'b1;
            wr_data  = rd_data & ~(64'd1 << off_q);
            res_ok_d = 1'b1;
          end
        end else if (hit.found) begin
          wr_en    = 1'b1;
          wr_data  = rd_data | (64'd1 << hit.idx);
          res_id_d = ID_W'({addr_q, hit.idx});
          res_ok_d = 1'b1;
        end else if (!last_word) begin
          addr_d = next_addr;
          off_d  = '0;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_id_d    = res_id_q;
          out_ok_d    = res_ok_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    addr_q   <= addr_d;
    off_q    <= off_d;
    res_id_q <= res_id_d;
    res_ok_q <= res_ok_d;
    out_id_q <= out_id_d;
    out_ok_q <= out_ok_d;
  end

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = out_id_q;
  assign ok_o         = out_ok_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("request accepted during clearing pass");

  a_grant_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_id_o != '0) |-> ok_o)
    else $error("nonzero identifier returned without ok");

  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, granted_id_o} < IdLimit))
    else $error("granted identifier outside the identifier space");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_EVAL || state_q == ST_CLEAR))
    else $error("map written outside scan or clearing pass");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;
  import lfa_pkg::*;

  localparam int IDS        = 32768;
  localparam int WORDS      = IDS / WORD_W;
  localparam int CYCLE_CAP  = 4_000_000;
  localparam int HOLD_SPAN  = 400;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic            ok;
  } grant_t;

  logic            clk;
  logic            rst_n;
  logic            req_valid;
  logic            req_stall;
  logic            req_op;
  logic [ID_W-1:0] req_start_id;
  logic [ID_W-1:0] req_release_id;
  logic            rsp_valid;
  logic            rsp_stall;
  logic [ID_W-1:0] rsp_granted_id;
  logic            rsp_ok;

  logic [WORD_W-1:0] used_words [WORDS];
  grant_t            pending_grants [$];
  int                held_ids [$];
  int                mismatch_count;
  int                cycle_count;
  int                burst_left;
  int                stall_mode;
  int                hold_left;
  bit                hold_req;
  bit                quiet;

  lowest_free_id_allocator_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_stall_o   (req_stall),
    .op_i         (req_op),
    .start_id_i   (req_start_id),
    .release_id_i (req_release_id),
    .out_valid_o  (rsp_valid),
    .out_stall_i  (rsp_stall),
    .granted_id_o (rsp_granted_id),
    .ok_o         (rsp_ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the local copy of the map and returns its result.
  function automatic grant_t apply_request(lfa_op_e op, logic [ID_W-1:0] s,
                                           logic [ID_W-1:0] r);
    grant_t g;
    int     id;
    g  = '0;
    if (op == OP_ALLOC) begin
      id = (s == '0) ? 1 : int'(s);
      while (id < IDS && !g.ok) begin
        if (id % WORD_W == 0 && &used_words[id / WORD_W]) begin
          id += WORD_W;
        end else if (!used_words[id / WORD_W][id % WORD_W]) begin
          used_words[id / WORD_W][id % WORD_W] = 1'b1;
          g.granted_id = ID_W'(id);
          g.ok = 1'b1;
          held_ids.insert(held_ids.size(), id);
        end else begin
          id++;
        end
      end
    end else begin
      id = int'(r);
      if (id != 0 && id < IDS && used_words[id / WORD_W][id % WORD_W]) begin
        used_words[id / WORD_W][id % WORD_W] = 1'b0;
        g.ok = 1'b1;
      end
    end
    return g;
  endfunction

  task automatic send_request(lfa_op_e op, logic [ID_W-1:0] s, logic [ID_W-1:0] r);
    int     gap;
    grant_t expd;
    req_op = op;
    req_start_id = s;
    req_release_id = r;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    expd = apply_request(op, s, r);
    pending_grants.insert(pending_grants.size(), expd);
    @(negedge clk);
    if (!quiet) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 15);
        burst_left = $urandom_range(1, 24);
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Most allocations start in a few crowded regions so that scans cross full
  // words and the top of the space runs out; releases mostly hit held IDs.
  task automatic random_request(int alloc_pct, int release_pct);
    int          pick;
    int          base;
    int unsigned idx;
    int          id;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      case ($urandom_range(0, 3))
        0: base = 0;
        1: base = 640;
        2: base = 5000;
        default: base = 32587;
      endcase
      send_request(OP_ALLOC, ID_W'(base + $urandom_range(0, 180)), ID_W'($urandom));
    end else if (pick < alloc_pct + release_pct && held_ids.size() != 0) begin
      idx = $urandom_range(0, held_ids.size() - 1);
      id = held_ids[idx];
      held_ids.delete(idx);
      send_request(OP_RELEASE, ID_W'($urandom), ID_W'(id));
    end else begin
      send_request(lfa_op_e'($urandom_range(0, 1)), ID_W'($urandom), ID_W'($urandom));
    end
  endtask

  task automatic stop_requests();
    req_valid = 1'b0;
  endtask

  task automatic test_alloc_edges();
    send_request(OP_ALLOC, 15'd0, ID_W'($urandom));
    send_request(OP_ALLOC, 15'd0, ID_W'($urandom));
    send_request(OP_ALLOC, 15'd1, ID_W'($urandom));
    send_request(OP_ALLOC, 15'd32767, ID_W'($urandom));
    send_request(OP_ALLOC, 15'd32767, ID_W'($urandom));
    send_request(OP_ALLOC, 15'd32766, ID_W'($urandom));
    send_request(OP_ALLOC, 15'd32765, ID_W'($urandom));
    send_request(OP_ALLOC, 15'h5555, ID_W'($urandom));
    send_request(OP_ALLOC, 15'h2AAA, ID_W'($urandom));
    send_request(OP_ALLOC, 15'd63, ID_W'($urandom));
    send_request(OP_ALLOC, 15'd63, ID_W'($urandom));
    send_request(OP_ALLOC, 15'd32704, ID_W'($urandom));
  endtask

  task automatic test_release_edges();
    send_request(OP_RELEASE, ID_W'($urandom), 15'd0);
    send_request(OP_RELEASE, ID_W'($urandom), 15'd32767);
    send_request(OP_RELEASE, ID_W'($urandom), 15'd32767);
    send_request(OP_RELEASE, ID_W'($urandom), 15'd2);
    send_request(OP_ALLOC, 15'd0, ID_W'($urandom));
    send_request(OP_RELEASE, ID_W'($urandom), 15'd12345);
    send_request(OP_RELEASE, 15'h7FFF, 15'h5555);
    send_request(OP_RELEASE, 15'h0000, 15'h2AAA);
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) random_request(55, 30);
  endtask

  task automatic test_stall_pressure(int count);
    hold_req = 1'b1;
    repeat (count) random_request(50, 35);
  endtask

  task automatic test_back_to_back(int count);
    quiet = 1'b1;
    repeat (count) random_request(50, 35);
    quiet = 1'b0;
  endtask

  task automatic test_release_drain(int count);
    repeat (count) random_request(20, 65);
  endtask

  // Response side: a changing stall pattern, plus one long hold-off on demand.
  initial begin
    rsp_stall = 1'b0;
    stall_mode = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_SPAN;
      end
      if (hold_left > 0) begin
        rsp_stall = 1'b1;
        hold_left--;
      end else if (quiet) begin
        rsp_stall = 1'b0;
      end else begin
        if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: rsp_stall = 1'b0;
          1: rsp_stall = ($urandom_range(0, 7) == 0);
          2: rsp_stall = ($urandom_range(0, 1) == 0);
          default: rsp_stall = (cycle_count % 5 < 2);
        endcase
      end
    end
  end

  task automatic note_mismatch(string what, int expd, int got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORT)
      $display("Mismatch on %s: expected %0d, got %0d (cycle %0d)", what, expd, got,
               cycle_count);
  endtask

  always @(posedge clk) begin
    grant_t expd;
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (pending_grants.size() == 0) begin
        note_mismatch("unexpected result granted_id", -1, int'(rsp_granted_id));
      end else begin
        expd = pending_grants.pop_front();
        if (rsp_granted_id !== expd.granted_id)
          note_mismatch("granted_id", int'(expd.granted_id), int'(rsp_granted_id));
        if (rsp_ok !== expd.ok)
          note_mismatch("ok", int'(expd.ok), int'(rsp_ok));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    req_valid = 1'b0;
    req_op = OP_ALLOC;
    req_start_id = '0;
    req_release_id = '0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    hold_req = 1'b0;
    quiet = 1'b0;
    foreach (used_words[i]) used_words[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_alloc_edges();
    test_release_edges();
    test_random_traffic(1000);
    test_stall_pressure(40);
    test_back_to_back(250);
    test_release_drain(400);

    stop_requests();
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/lfa_pkg.sv
hw/rtl/lfa_map_ram.sv
hw/rtl/lfa_word_search.sv
hw/rtl/lowest_free_id_allocator_core.sv
sim/testbench.sv
